>>> rtl/core/dssb_pkg.sv
// ----------------------------------------------------------------------------
// dssb_pkg
// Types and constants shared by the dual stack shared buffer modules.
// ----------------------------------------------------------------------------
package dssb_pkg;

    localparam logic [6:0] CAP_RESET  = 7'd64;
    localparam int         CAP_W      = 7;
    localparam int         DATA_W     = 32;

    typedef enum logic [1:0] {
        MODE_PUSH_FIRST  = 2'd0,
        MODE_PUSH_SECOND = 2'd1,
        MODE_POP_FIRST   = 2'd2,
        MODE_POP_SECOND  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_READ = 1'b1
    } fsm_t;

    typedef struct packed {
        logic             wr;
        logic [CAP_W-1:0] wr_cap;
        logic [CAP_W-1:0] cap;
    } cfg_bus_t;

endpackage

>>> rtl/core/dssb_ram.sv
// ----------------------------------------------------------------------------
// dssb_ram
// Single-port synchronous store with a registered read.
// ----------------------------------------------------------------------------
module dssb_ram
    import dssb_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [DATA_W-1:0]        wdata,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_array [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/dssb_cfg.sv
// ----------------------------------------------------------------------------
// dssb_cfg
// APB register file holding the capacity register.
// ----------------------------------------------------------------------------
module dssb_cfg
    import dssb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_bus_t    cfg
);

    logic             cap_sel;
    logic             wr_en;
    logic [CAP_W-1:0] capacity_reg;

    assign cap_sel = (paddr[2] == 1'b0);
    assign wr_en   = psel && penable && pwrite && cap_sel;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (wr_en)
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata     = cap_sel ? {{(32-CAP_W){1'b0}}, capacity_reg} : 32'd0;
    assign cfg.wr     = wr_en;
    assign cfg.wr_cap = pwdata[CAP_W-1:0];
    assign cfg.cap    = capacity_reg;

endmodule

>>> rtl/core/dssb_ctrl.sv
// ----------------------------------------------------------------------------
// dssb_ctrl
// Stack pointers, cached tops, store access sequencing and the result register.
// ----------------------------------------------------------------------------
module dssb_ctrl
    import dssb_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_bus_t                 cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               in_mode,
    input  logic [DATA_W-1:0]        in_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               out_status,
    output logic [DATA_W-1:0]        out_first_top,
    output logic [DATA_W-1:0]        out_second_top,
    output logic                     out_first_empty,
    output logic                     out_second_empty,
    output logic [CAP_W-1:0]         out_first_depth,
    output logic [CAP_W-1:0]         out_second_depth,
    output logic                     mem_we,
    output logic                     mem_re,
    output logic [$clog2(DEPTH)-1:0] mem_addr,
    output logic [DATA_W-1:0]        mem_wdata,
    input  logic [DATA_W-1:0]        mem_rdata
);

    localparam int PW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = (PW > CAP_W) ? PW : CAP_W;
    localparam logic [CW-1:0] DEPTH_CW = CW'(DEPTH);
    localparam logic [PW-1:0] BASE_RESET = (DEPTH < 64) ? PW'(DEPTH) : PW'(64);

    fsm_t              state_reg, state_next;
    logic [PW-1:0]     first_count_reg, first_count_next;
    logic [PW-1:0]     second_base_reg, second_base_next;
    logic [DATA_W-1:0] first_top_reg, first_top_next;
    logic [DATA_W-1:0] second_top_reg, second_top_next;
    logic              pend_first_reg, pend_first_next;

    logic              out_valid_reg;
    logic [1:0]        out_status_reg;
    logic [DATA_W-1:0] out_first_top_reg, out_second_top_reg;
    logic              out_first_empty_reg, out_second_empty_reg;
    logic [CAP_W-1:0]  out_first_depth_reg, out_second_depth_reg;

    logic          accept;
    logic          need_read;
    logic          load_out;
    status_t       status_next;
    logic [CW-1:0] cap_ext, wr_cap_ext;
    logic [PW-1:0] cap_eff, wr_cap_eff;
    logic [PW-1:0] first_inc, first_dec, first_dec2, base_inc, base_dec;
    logic          full;
    logic          first_none, second_none;
    logic          e1_next, e2_next;
    logic [PW-1:0] depth2_next;

    assign cap_ext    = CW'(cfg.cap);
    assign wr_cap_ext = CW'(cfg.wr_cap);
    assign cap_eff    = (cap_ext > DEPTH_CW) ? PW'(DEPTH) : PW'(cap_ext);
    assign wr_cap_eff = (wr_cap_ext > DEPTH_CW) ? PW'(DEPTH) : PW'(wr_cap_ext);

    assign first_inc  = first_count_reg + 1'b1;
    assign first_dec  = first_count_reg - 1'b1;
    assign first_dec2 = first_count_reg - PW'(2);
    assign base_inc   = second_base_reg + 1'b1;
    assign base_dec   = second_base_reg - 1'b1;

    assign full        = (first_count_reg >= second_base_reg);
    assign first_none  = (first_count_reg == '0);
    assign second_none = (second_base_reg >= cap_eff);

    assign in_ready = (state_reg == FSM_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign need_read = ((in_mode == MODE_POP_FIRST) && (first_count_reg > PW'(1)))
                    || ((in_mode == MODE_POP_SECOND) && !second_none && (base_inc < cap_eff));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (accept && need_read)
                begin
                    state_next = FSM_READ;
                end
            end
            FSM_READ:
            begin
                state_next = FSM_IDLE;
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        first_count_next = first_count_reg;
        second_base_next = second_base_reg;
        first_top_next   = first_top_reg;
        second_top_next  = second_top_reg;
        pend_first_next  = pend_first_reg;
        status_next      = ST_OK;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_addr         = '0;
        mem_wdata        = in_value;
        load_out         = 1'b0;

        if (cfg.wr)
        begin
            first_count_next = '0;
            second_base_next = wr_cap_eff;
        end
        else if (state_reg == FSM_READ)
        begin
            load_out = 1'b1;
            if (pend_first_reg)
            begin
                first_top_next = mem_rdata;
            end
            else
            begin
                second_top_next = mem_rdata;
            end
        end
        else if (accept)
        begin
            load_out = !need_read;
            case (in_mode)
                MODE_PUSH_FIRST:
                begin
                    if (full)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        mem_we           = 1'b1;
                        mem_addr         = first_count_reg[AW-1:0];
                        first_count_next = first_inc;
                        first_top_next   = in_value;
                    end
                end
                MODE_PUSH_SECOND:
                begin
                    if (full)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        mem_we           = 1'b1;
                        mem_addr         = base_dec[AW-1:0];
                        second_base_next = base_dec;
                        second_top_next  = in_value;
                    end
                end
                MODE_POP_FIRST:
                begin
                    if (first_none)
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        first_count_next = first_dec;
                        pend_first_next  = 1'b1;
                        mem_re           = need_read;
                        mem_addr         = first_dec2[AW-1:0];
                    end
                end
                default:
                begin
                    if (second_none)
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        second_base_next = base_inc;
                        pend_first_next  = 1'b0;
                        mem_re           = need_read;
                        mem_addr         = base_inc[AW-1:0];
                    end
                end
            endcase
        end
    end

    assign e1_next     = (first_count_next == '0);
    assign e2_next     = (second_base_next >= cap_eff);
    assign depth2_next = e2_next ? '0 : (cap_eff - second_base_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= FSM_IDLE;
            first_count_reg <= '0;
            second_base_reg <= BASE_RESET;
            pend_first_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            first_count_reg <= first_count_next;
            second_base_reg <= second_base_next;
            pend_first_reg  <= pend_first_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        first_top_reg  <= first_top_next;
        second_top_reg <= second_top_next;
        if (load_out)
        begin
            out_status_reg       <= status_next;
            out_first_top_reg    <= e1_next ? '1 : first_top_next;
            out_second_top_reg   <= e2_next ? '1 : second_top_next;
            out_first_empty_reg  <= e1_next;
            out_second_empty_reg <= e2_next;
            out_first_depth_reg  <= CAP_W'(first_count_next);
            out_second_depth_reg <= CAP_W'(depth2_next);
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_status       = out_status_reg;
    assign out_first_top    = out_first_top_reg;
    assign out_second_top   = out_second_top_reg;
    assign out_first_empty  = out_first_empty_reg;
    assign out_second_empty = out_second_empty_reg;
    assign out_first_depth  = out_first_depth_reg;
    assign out_second_depth = out_second_depth_reg;

endmodule

>>> rtl/core/dual_stack_shared_buffer_unit.sv
// ----------------------------------------------------------------------------
// dual_stack_shared_buffer_unit
// Two stacks sharing one store, driven by push and pop beats.
// Pushes and failed operations load the result when the beat is accepted; a pop
// whose new top must be fetched from the store's registered read port loads it
// from the read state; no new beat is taken outside the idle state.
// Reset empties both stacks and sets the capacity to 64; no store clearing.
// ----------------------------------------------------------------------------
module dual_stack_shared_buffer_unit
    import dssb_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] push_value
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] first_top, [63:32] second_top, [64] first_empty, [65] second_empty,
    // [72:66] first_depth, [79:73] second_depth
    output logic [79:0] m_tdata,
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_bus_t                 cfg;
    logic                     mem_we, mem_re;
    logic [$clog2(DEPTH)-1:0] mem_addr;
    logic [DATA_W-1:0]        mem_wdata, mem_rdata;
    logic [DATA_W-1:0]        first_top, second_top;
    logic                     first_empty, second_empty;
    logic [CAP_W-1:0]         first_depth, second_depth;

    dssb_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dssb_ctrl #(.DEPTH(DEPTH)) u_ctrl
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_mode          (s_tuser),
        .in_value         (s_tdata),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_status       (m_tuser),
        .out_first_top    (first_top),
        .out_second_top   (second_top),
        .out_first_empty  (first_empty),
        .out_second_empty (second_empty),
        .out_first_depth  (first_depth),
        .out_second_depth (second_depth),
        .mem_we           (mem_we),
        .mem_re           (mem_re),
        .mem_addr         (mem_addr),
        .mem_wdata        (mem_wdata),
        .mem_rdata        (mem_rdata)
    );

    dssb_ram #(.DEPTH(DEPTH)) u_ram
    (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign m_tdata = {second_depth, first_depth, second_empty, first_empty,
                      second_top, first_top};

endmodule

>>> rtl/core/dssb_checker.sv
// ----------------------------------------------------------------------------
// dssb_checker
// Port-level checks on the dual stack shared buffer unit, bound to the top.
// ----------------------------------------------------------------------------
module dssb_checker
    import dssb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Result beat changed while stalled.");

    a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready && m_tvalid |-> m_tready)
        else $error("Input taken while a result is stalled.");

    a_first_empty_depth: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[64] == (m_tdata[72:66] == 7'd0))
        else $error("First empty flag disagrees with its depth.");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[65] |-> m_tdata[63:32] == 32'hFFFF_FFFF
                                    && m_tdata[79:73] == 7'd0)
        else $error("Empty second stack reports a top or a depth.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser == ST_OK || m_tuser == ST_OVERFLOW
                     || m_tuser == ST_UNDERFLOW)
        else $error("Unknown status code.");

endmodule

bind dual_stack_shared_buffer_unit dssb_checker u_dssb_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
